FILE: rtl/ffra_pkg.sv
package ffra_pkg;

    localparam int MEM_SIZE    = 1024;
    localparam int MAX_ENTRIES = 128;
    localparam int HANDLES     = 128;

    localparam int ADDR_W = 10;
    localparam int SIZE_W = 11;
    localparam int HND_W  = 7;
    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W  = 18;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_BAD_SIZE   = 3'd3,
        ST_NOT_FOUND  = 3'd4
    } status_t;

    typedef struct packed {
        logic              command;
        logic [SIZE_W-1:0] req_size;
        logic [HND_W-1:0]  req_handle;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [HND_W-1:0]  granted_handle;
        logic [ADDR_W-1:0] granted_start;
    } rsp_t;

    typedef struct packed {
        logic [SUM_W-1:0]  start;
        logic [SIZE_W-1:0] length;
        logic [HND_W-1:0]  handle;
    } entry_t;

    // One shift step broadcast to every cell of the table.
    typedef struct packed {
        logic             active;
        logic [IDX_W-1:0] idx;
        logic             ins;
        logic             del;
        logic [CNT_W-1:0] total;
        entry_t           new_entry;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } fsm_t;

endpackage

FILE: rtl/ffra_cell.sv
module ffra_cell
    import ffra_pkg::*;
(
    input  logic             clk,
    input  logic [CNT_W-1:0] pos,
    input  cell_ctl_t        ctl,
    input  entry_t           left,
    input  entry_t           right,
    output entry_t           q
);

    entry_t q_reg;
    logic   pos_ge;
    logic   in_tab;

    assign q      = q_reg;
    assign pos_ge = (pos >= {1'b0, ctl.idx});
    assign in_tab = (pos <= ctl.total);

    // Insertion moves the tail up one slot and writes the new entry at idx;
    // deletion pulls the tail down one slot.
    always_ff @(posedge clk)
    begin
        if (ctl.active && in_tab)
        begin
            if (ctl.ins && pos_ge)
            begin
                if (pos == {1'b0, ctl.idx})
                    q_reg <= ctl.new_entry;
                else
                    q_reg <= left;
            end
            else if (ctl.del && pos_ge)
            begin
                q_reg <= right;
            end
        end
    end

endmodule

FILE: rtl/ffra_table.sv
module ffra_table
    import ffra_pkg::*;
(
    input  logic             clk,
    input  cell_ctl_t        ctl,
    input  logic [IDX_W-1:0] rd_idx,
    output entry_t           rd_entry
);

    entry_t cells [MAX_ENTRIES];
    entry_t right_of [MAX_ENTRIES];
    entry_t left_of [MAX_ENTRIES];
    entry_t rd_entry_reg;

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_cell
        if (g == 0)
            assign left_of[g] = ctl.new_entry;
        else
            assign left_of[g] = cells[g-1];
        if (g == MAX_ENTRIES - 1)
            assign right_of[g] = cells[g];
        else
            assign right_of[g] = cells[g+1];

        ffra_cell u_cell (
            .clk   (clk),
            .pos   (CNT_W'(g)),
            .ctl   (ctl),
            .left  (left_of[g]),
            .right (right_of[g]),
            .q     (cells[g])
        );
    end

    // The read address is the scan position of the coming cycle, so the
    // registered entry lines up with the scan position once it is current.
    always_ff @(posedge clk)
    begin
        rd_entry_reg <= cells[rd_idx];
    end

    assign rd_entry = rd_entry_reg;

endmodule

FILE: rtl/first_fit_region_allocator.sv
// Channel | Direction | Payload | Handshake
// request | in        | req_t   | req_valid / req_ready
// response| out       | rsp_t   | rsp_valid / rsp_ready
// After acceptance a request scans one table entry per cycle and then checks the
// tail at the entry count; on success it shifts the table in S_SHIFT before it
// responds. A zero size or a full table or handle map skips the scan and the
// shift. No request is taken while one is in flight, so the scan of the entry
// table sets how often requests can be taken.
// Reset clears the entry count and handle map; table contents need no reset.
// A stalled response holds; the next request is taken once it is delivered.
module first_fit_region_allocator
    import ffra_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    fsm_t              state_reg, state_next;
    req_t              req_reg, req_next;
    rsp_t              rsp_reg, rsp_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [SUM_W-1:0]  start_reg, start_next;
    logic              ins_reg, ins_next;
    logic [HANDLES-1:0] used_reg, used_next;
    logic [HND_W-1:0]  free_h;
    logic              any_free;
    cell_ctl_t         ctl;
    entry_t            rd_entry;
    logic [SUM_W-1:0]  need;

    always_comb
    begin
        free_h   = '0;
        any_free = 1'b0;
        for (int i = HANDLES - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_h   = HND_W'(i);
                any_free = 1'b1;
            end
        end
    end

    ffra_table u_table (
        .clk      (clk),
        .ctl      (ctl),
        .rd_idx   (pos_next[IDX_W-1:0]),
        .rd_entry (rd_entry)
    );

    assign need      = start_reg + SUM_W'(req_reg.req_size);
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_DONE);
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        rsp_reg   <= rsp_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        start_reg <= start_next;
        ins_reg   <= ins_next;
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        rsp_next   = rsp_reg;
        total_next = total_reg;
        used_next  = used_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        ins_next   = ins_reg;
        ctl        = '0;
        ctl.idx    = idx_reg;
        ctl.total  = total_reg;
        ctl.new_entry.start  = start_reg;
        ctl.new_entry.length = req_reg.req_size;
        ctl.new_entry.handle = free_h;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    pos_next   = '0;
                    start_next = '0;
                    rsp_next   = '0;
                    state_next = S_SCAN;
                    if (req.command == CMD_ALLOC)
                    begin
                        if (req.req_size == '0)
                        begin
                            rsp_next.status = ST_BAD_SIZE;
                            state_next      = S_DONE;
                        end
                        else if (total_reg >= CNT_W'(MAX_ENTRIES) || !any_free)
                        begin
                            rsp_next.status = ST_TABLE_FULL;
                            state_next      = S_DONE;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (pos_reg == total_reg)
                begin
                    idx_next = pos_reg[IDX_W-1:0];
                    if (req_reg.command == CMD_ALLOC &&
                        need <= SUM_W'(MEM_SIZE))
                    begin
                        ins_next   = 1'b1;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        rsp_next.status = (req_reg.command == CMD_ALLOC) ?
                                          ST_NO_SPACE : ST_NOT_FOUND;
                        state_next = S_DONE;
                    end
                end
                else if (req_reg.command == CMD_ALLOC)
                begin
                    if (need <= rd_entry.start)
                    begin
                        idx_next   = pos_reg[IDX_W-1:0];
                        ins_next   = 1'b1;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        start_next = rd_entry.start + SUM_W'(rd_entry.length);
                        pos_next   = pos_reg + 1'b1;
                    end
                end
                else
                begin
                    if (rd_entry.handle == req_reg.req_handle)
                    begin
                        idx_next   = pos_reg[IDX_W-1:0];
                        ins_next   = 1'b0;
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            S_SHIFT:
            begin
                ctl.active = 1'b1;
                ctl.ins    = ins_reg;
                ctl.del    = !ins_reg;
                rsp_next.status = ST_OK;
                if (ins_reg)
                begin
                    rsp_next.granted_handle = free_h;
                    rsp_next.granted_start  = start_reg[ADDR_W-1:0];
                    used_next[free_h]       = 1'b1;
                    total_next              = total_reg + 1'b1;
                end
                else
                begin
                    used_next[req_reg.req_handle] = 1'b0;
                    total_next                    = total_reg - 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
